>>> src/bpra_pkg.sv
package bpra_pkg;

  localparam int ROW_BITS       = 8;
  localparam int ROW_SHIFT      = 3;
  localparam int NUM_POOLS      = 4;
  localparam int DEF_POOL_PAGES = 1024;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int PAGES_REG_W    = 11;
  localparam int COUNT_W        = 11;

  localparam logic [31:0] KV_BASE_RESET = 32'hC010_0000;
  localparam logic [PAGES_REG_W-1:0] PAGES_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KV_BASE,
    REG_UV_BASE,
    REG_KP_BASE,
    REG_UP_BASE,
    REG_KV_PAGES,
    REG_UV_PAGES,
    REG_KP_PAGES,
    REG_UP_PAGES
  } reg_index_t;

  typedef enum logic [1:0] {
    POOL_KVIRT,
    POOL_UVIRT,
    POOL_KPHYS,
    POOL_UPHYS
  } pool_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK_INIT,
    ST_MARK,
    ST_ADDR,
    ST_SUM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_SHIFT-1:0] pos;
  } scan_hit_t;

endpackage

>>> src/bpra_byte_scan.sv
module bpra_byte_scan import bpra_pkg::*; #(
  parameter int CNT_W = 11
) (
  input  logic [ROW_BITS-1:0] bits,
  input  logic [CNT_W-1:0]    base_idx,
  input  logic [CNT_W-1:0]    span,
  input  logic [CNT_W-1:0]    want,
  input  logic [CNT_W-1:0]    run_in,
  output logic [CNT_W-1:0]    run_out,
  output scan_hit_t           hit
);

  // Walk the row one page at a time; pages at or past the span are skipped.
  always_comb begin
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] idx;
    run = run_in;
    hit = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx = base_idx | CNT_W'(j);
      if (idx < span) begin
        if (bits[j]) begin
          run = '0;
        end else begin
          run = run + CNT_W'(1);
        end
        if (!hit.hit && run == want) begin
          hit.hit = 1'b1;
          hit.pos = ROW_SHIFT'(j);
        end
      end
    end
    run_out = run;
  end

endmodule

>>> src/bitmap_page_run_allocator.sv
// Flow: a check state, then a scan of the bitmap rows up to the end of the run, a marking
// pass over the rows the run touches, and address, sum and result states; a search that
// finds no run scans every row of the span.
// Throughput: one request at a time; the bitmap row walk (8 pages a cycle) sets the figure.
// Reset: synchronous; config returns to defaults, then a clearing pass writes every
// bitmap row, with in_stall held high.
module bitmap_page_run_allocator import bpra_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            pool,
  input  logic [COUNT_W-1:0]    page_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  granted,
  output logic [31:0]           address
);

  localparam int RPP     = (POOL_PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROWS    = NUM_POOLS * RPP;
  localparam int AW      = $clog2(ROWS);
  localparam int RW      = (RPP > 1) ? $clog2(RPP) : 1;
  localparam int IDX_W   = $clog2(RPP * ROW_BITS + 1);
  localparam int CNT_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam logic [31:0] PAGE_BYTES_W = 32'(PAGE_BYTES);

  state_t state, state_next;

  logic [31:0]            base_reg  [NUM_POOLS];
  logic [PAGES_REG_W-1:0] pages_reg [NUM_POOLS];

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] mem_q;
  logic [ROW_BITS-1:0] mark_mask;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       pool_row_base;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [ROW_BITS-1:0] wr_row;
  logic                mem_we;

  logic [1:0]       cur_pool;
  logic [CNT_W-1:0] cur_want;
  logic [CNT_W-1:0] span_c;
  logic [CNT_W-1:0] span_r;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_out;
  logic [CNT_W-1:0] start;
  logic [CNT_W-1:0] mark_end;
  logic [CNT_W-1:0] base_idx;
  logic [RW-1:0]    rd_row;
  logic [RW-1:0]    proc_row;
  logic [RW-1:0]    last_row;
  logic             rd_active;
  logic             proc_valid;
  logic             req_fail;
  logic             proc_last;
  logic             in_xfer;
  logic             out_free;
  scan_hit_t        scan_hit;

  logic [31:0] prod;
  logic        res_granted;
  logic [31:0] res_addr;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign proc_last = proc_valid && (proc_row == last_row);

  assign span_c = (CNT_W'(pages_reg[cur_pool]) > CNT_W'(POOL_PAGES)) ?
                  CNT_W'(POOL_PAGES) : CNT_W'(pages_reg[cur_pool]);
  assign req_fail = (cur_want == '0) || (cur_want > span_c);

  assign base_idx = CNT_W'({proc_row, {ROW_SHIFT{1'b0}}});

  bpra_byte_scan #(.CNT_W(CNT_W)) u_scan (
    .bits     (mem_q),
    .base_idx (base_idx),
    .span     (span_r),
    .want     (cur_want),
    .run_in   (run),
    .run_out  (run_out),
    .hit      (scan_hit)
  );

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      mark_mask[j] = ((base_idx | CNT_W'(j)) >= start) && ((base_idx | CNT_W'(j)) < mark_end);
    end
  end

  assign rd_addr = pool_row_base + AW'(rd_row);
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : pool_row_base + AW'(proc_row);
  assign wr_row  = (state == ST_CLEAR) ? '0 : (mem_q | mark_mask);
  assign mem_we  = (state == ST_CLEAR) || ((state == ST_MARK) && proc_valid);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    mem_q <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg[POOL_KVIRT] <= KV_BASE_RESET;
      base_reg[POOL_UVIRT] <= '0;
      base_reg[POOL_KPHYS] <= '0;
      base_reg[POOL_UPHYS] <= '0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        pages_reg[p] <= PAGES_RESET;
      end
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_KV_BASE:  base_reg[POOL_KVIRT]  <= wr_data;
        REG_UV_BASE:  base_reg[POOL_UVIRT]  <= wr_data;
        REG_KP_BASE:  base_reg[POOL_KPHYS]  <= wr_data;
        REG_UP_BASE:  base_reg[POOL_UPHYS]  <= wr_data;
        REG_KV_PAGES: pages_reg[POOL_KVIRT] <= wr_data[PAGES_REG_W-1:0];
        REG_UV_PAGES: pages_reg[POOL_UVIRT] <= wr_data[PAGES_REG_W-1:0];
        REG_KP_PAGES: pages_reg[POOL_KPHYS] <= wr_data[PAGES_REG_W-1:0];
        REG_UP_PAGES: pages_reg[POOL_UPHYS] <= wr_data[PAGES_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr_addr == AW'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (in_xfer) state_next = ST_CHECK;
      ST_CHECK:     state_next = req_fail ? ST_RESULT : ST_SCAN;
      ST_SCAN: begin
        if (proc_valid && scan_hit.hit) begin
          state_next = ST_MARK_INIT;
        end else if (proc_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_MARK_INIT: state_next = ST_MARK;
      ST_MARK:      if (proc_last) state_next = ST_ADDR;
      ST_ADDR:      state_next = ST_SUM;
      ST_SUM:       state_next = ST_RESULT;
      ST_RESULT:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath and row walk
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      rd_active  <= 1'b0;
      proc_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        ST_IDLE: begin
          if (in_xfer) begin
            cur_pool <= pool;
            if (pool == POOL_KPHYS || pool == POOL_UPHYS) begin
              cur_want <= CNT_W'(1);
            end else begin
              cur_want <= CNT_W'(page_count);
            end
          end
        end
        ST_CHECK: begin
          span_r        <= span_c;
          pool_row_base <= AW'(cur_pool) * AW'(RPP);
          run           <= '0;
          rd_row        <= '0;
          last_row      <= RW'((span_c - CNT_W'(1)) >> ROW_SHIFT);
          rd_active     <= !req_fail;
          proc_valid    <= 1'b0;
          res_granted   <= 1'b0;
          res_addr      <= '0;
        end
        ST_SCAN, ST_MARK: begin
          if (rd_active) begin
            rd_row <= rd_row + RW'(1);
            if (rd_row == last_row) begin
              rd_active <= 1'b0;
            end
          end
          proc_valid <= rd_active;
          proc_row   <= rd_row;
          if (state == ST_SCAN && proc_valid) begin
            run <= run_out;
            if (scan_hit.hit) begin
              // drop the read still in flight
              rd_active  <= 1'b0;
              proc_valid <= 1'b0;
              start      <= (base_idx | CNT_W'(scan_hit.pos)) + CNT_W'(1) - cur_want;
            end
          end
          if (proc_last) begin
            rd_active  <= 1'b0;
            proc_valid <= 1'b0;
          end
        end
        ST_MARK_INIT: begin
          mark_end   <= start + cur_want;
          rd_row     <= RW'(start >> ROW_SHIFT);
          last_row   <= RW'((start + cur_want - CNT_W'(1)) >> ROW_SHIFT);
          rd_active  <= 1'b1;
          proc_valid <= 1'b0;
        end
        ST_ADDR: begin
          prod <= 32'(start) * PAGE_BYTES_W;
        end
        ST_SUM: begin
          res_granted <= 1'b1;
          res_addr    <= base_reg[cur_pool] + prod;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
        granted   <= res_granted;
        address   <= res_addr;
      end
    end
  end

endmodule

>>> bench/bitmap_page_run_allocator_tb.sv
module bitmap_page_run_allocator_tb;
  import bpra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pool_t              pool;
    logic [COUNT_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] address;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            pool = '0;
  logic [COUNT_W-1:0]    page_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  granted;
  logic [31:0]           address;

  // predictor copy of the allocator: page bitmaps and pool registers
  bit                   page_used [NUM_POOLS][DEF_POOL_PAGES];
  logic [31:0]          pool_base [NUM_POOLS];
  logic [PAGES_REG_W-1:0] pool_pages [NUM_POOLS];

  request_t request_q[$];
  grant_t   grant_q[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatches = 0;
  logic     hold_go = 1'b0;
  int       hold_left = 0;

  bitmap_page_run_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pool       (pool),
    .page_count (page_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted    (granted),
    .address    (address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first fit: lowest free run inside the pool span, then mark it used
  function automatic grant_t allocate_run(pool_t p, logic [COUNT_W-1:0] count);
    int     span;
    int     want;
    int     run;
    int     first;
    grant_t g;
    span = (pool_pages[p] > DEF_POOL_PAGES) ? DEF_POOL_PAGES : int'(pool_pages[p]);
    want = (p == POOL_KPHYS || p == POOL_UPHYS) ? 1 : int'(count);
    g = '0;
    first = -1;
    run = 0;
    if (want != 0 && want <= span) begin
      for (int i = 0; i < span && first < 0; i++) begin
        run = page_used[p][i] ? 0 : run + 1;
        if (run == want) first = i + 1 - want;
      end
    end
    if (first >= 0) begin
      for (int i = first; i < first + want; i++) page_used[p][i] = 1'b1;
      g.granted = 1'b1;
      g.address = pool_base[p] + 32'(first) * 32'(DEF_PAGE_BYTES);
    end
    return g;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r.pool = pool_t'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 75) r.count = COUNT_W'($urandom_range(8, 1));
    else if (pick < 90) r.count = COUNT_W'($urandom_range(64, 9));
    else if (pick < 93) r.count = (pick % 2 == 0) ? '0 : '1;
    else r.count = COUNT_W'($urandom_range(2047));
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [32:0] exp_val, logic [32:0] act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h at %0t", field, exp_val, act_val, $time);
  endtask

  task automatic push_req(pool_t p, int c);
    request_q.push_back('{p, COUNT_W'(c)});
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    if (idx < REG_KV_PAGES) pool_base[idx] = value;
    else pool_pages[idx - REG_KV_PAGES] = value[PAGES_REG_W-1:0];
  endtask

  task automatic close_writes();
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (request_q.size() != 0 || grant_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // request driver: hold a stalled transfer, otherwise offer the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        grant_q.push_back(allocate_run(pool_t'(pool), page_count));
        request_q.delete(0);
      end
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        pool <= request_q[0].pool;
        page_count <= request_q[0].count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("unexpected result", 33'd0, {granted, address});
        end else begin
          want = grant_q.pop_front();
          if (granted !== want.granted) flag_mismatch("granted", want.granted, granted);
          if (address !== want.address) flag_mismatch("address", want.address, address);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int pg;
    int mode;
    int n;
    foreach (page_used[p, i]) page_used[p][i] = 1'b0;
    pool_base[POOL_KVIRT] = KV_BASE_RESET;
    pool_base[POOL_UVIRT] = '0;
    pool_base[POOL_KPHYS] = '0;
    pool_base[POOL_UPHYS] = '0;
    foreach (pool_pages[p]) pool_pages[p] = PAGES_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // wait out the bitmap clearing pass
    do @(posedge clk); while (in_stall);

    // reset settings: zero count, physical count ignored, run longer than free space
    push_req(POOL_KVIRT, 1);
    push_req(POOL_KVIRT, 0);
    push_req(POOL_UVIRT, 1);
    push_req(POOL_KPHYS, 0);
    push_req(POOL_UPHYS, 2047);
    push_req(POOL_KVIRT, 2047);
    push_req(POOL_UVIRT, 1024);
    wait_idle();

    // address wrap, empty pool, single-page pool, pages register above capacity
    write_reg(REG_KV_BASE, 32'hFFFF_F000);
    write_reg(REG_UV_BASE, 32'hFFFF_FFFF);
    write_reg(REG_KP_BASE, 32'h0000_0000);
    write_reg(REG_UP_BASE, 32'h8000_0000);
    write_reg(REG_KV_PAGES, 32'd5);
    write_reg(REG_UV_PAGES, 32'd0);
    write_reg(REG_KP_PAGES, 32'hFFFF_F801);
    write_reg(REG_UP_PAGES, 32'd2047);
    close_writes();
    push_req(POOL_KVIRT, 4);
    push_req(POOL_KVIRT, 1);
    push_req(POOL_KVIRT, 5);
    push_req(POOL_UVIRT, 1);
    push_req(POOL_UVIRT, 0);
    push_req(POOL_KPHYS, 1);
    push_req(POOL_UPHYS, 1);
    push_req(POOL_UPHYS, 0);
    push_req(POOL_KVIRT, 1024);
    wait_idle();

    // random phases with growing spans, then shrunken and oversized spans
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_POOLS; r++)
        write_reg(reg_index_t'(r), (ph == 5) ? 32'h0 : 32'($urandom));
      for (int r = 0; r < NUM_POOLS; r++) begin
        case (ph)
          0: pg = 64;
          1: pg = 128;
          2: pg = 256;
          3: pg = 1024;
          4: pg = $urandom_range(2047);
          default: pg = 2047;
        endcase
        write_reg(reg_index_t'(NUM_POOLS + r), {21'($urandom), 11'(pg)});
      end
      close_writes();

      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 76 : (mode == 3) ? 9 : 0;
      recv_stall_pct = (mode == 2) ? 76 : (mode == 3) ? 9 : 0;
      n = (ph == 0 || ph == 4) ? 150 : (ph == 5) ? 190 : 250;

      if (ph == 2) begin
        // pause the sender until every outstanding grant has come back
        repeat (n / 2) request_q.push_back(random_request());
        wait_idle();
        repeat (n - n / 2) request_q.push_back(random_request());
      end else begin
        repeat (n) request_q.push_back(random_request());
      end

      if (ph == 0) begin
        // hold off the receiver while requests keep coming so the block backs up
        do @(posedge clk); while (request_q.size() > n - 10);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/bpra_pkg.sv
src/bpra_byte_scan.sv
src/bitmap_page_run_allocator.sv
bench/bitmap_page_run_allocator_tb.sv
